>>> design/lzss_dec_pkg.sv
// Shared types and constants for the LZSS byte decompressor.
package lzss_dec_pkg;

	localparam int WINDOW_SIZE = 4096;
	localparam int WIN_AW      = $clog2(WINDOW_SIZE);
	localparam int FILL_W      = WIN_AW + 1;
	localparam int CMD_DEPTH   = 4;
	localparam int CMD_AW      = $clog2(CMD_DEPTH);
	localparam int LEN_W       = 5;

	localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(4078);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_SIZE);
	localparam logic [LEN_W-1:0]  LEN_BIAS  = LEN_W'(3);
	localparam logic [3:0]        FLAG_BITS = 4'd8;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BODY,
		PH_MATCH2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_FRAME,
		CMD_LIT,
		CMD_MATCH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [WIN_AW-1:0] off;
		logic [7:0]        lit;
		logic [LEN_W-1:0]  len;
		logic              done;
	} cmd_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_start;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_done;
	} out_req_t;

endpackage

>>> design/lzss_dec_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzss_dec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/lzss_dec_parser.sv
// Front end: header capture, control-bit parsing and command generation.
module lzss_dec_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  lzss_dec_pkg::in_req_t req,
	output logic                  cmd_push,
	output lzss_dec_pkg::cmd_t    cmd,
	input  logic                  cmd_full
);

	lzss_dec_pkg::phase_t phase_q, phase_n;
	logic [2:0]  hdr_q, hdr_n;
	logic [31:0] left_q, left_n;
	logic [31:0] packed_q, packed_n;
	logic [31:0] consumed_q, consumed_n;
	logic [7:0]  flag_q, flag_n;
	logic [3:0]  flags_left_q, flags_left_n;
	logic [7:0]  low_q, low_n;
	logic        fin_q, fin_n;
	logic        accept;

	assign req_stall = cmd_full;
	assign accept    = req_valid && !cmd_full;

	always_comb begin
		logic [7:0]                      b;
		logic [lzss_dec_pkg::LEN_W-1:0] len_raw;
		logic [lzss_dec_pkg::LEN_W-1:0] n;
		logic                            check;
		b            = req.in_byte;
		len_raw      = lzss_dec_pkg::LEN_W'(b[3:0]) + lzss_dec_pkg::LEN_BIAS;
		n            = '0;
		check        = 1'b0;
		phase_n      = phase_q;
		hdr_n        = hdr_q;
		left_n       = left_q;
		packed_n     = packed_q;
		consumed_n   = consumed_q;
		flag_n       = flag_q;
		flags_left_n = flags_left_q;
		low_n        = low_q;
		fin_n        = fin_q;
		cmd_push     = 1'b0;
		cmd.kind     = lzss_dec_pkg::CMD_FRAME;
		cmd.off      = {b[7:4], low_q};
		cmd.lit      = b;
		cmd.len      = lzss_dec_pkg::LEN_W'(1);
		cmd.done     = 1'b0;
		if (accept) begin
			if (req.frame_start) begin
				phase_n      = lzss_dec_pkg::PH_HEADER;
				hdr_n        = 3'd1;
				left_n       = {24'd0, b};
				packed_n     = '0;
				consumed_n   = '0;
				flag_n       = '0;
				flags_left_n = '0;
				low_n        = '0;
				fin_n        = 1'b0;
				cmd_push     = 1'b1;
			end else begin
				case (phase_q)
					lzss_dec_pkg::PH_HEADER: begin
						if (!hdr_q[2]) begin
							left_n = {left_q[23:0], b};
						end else begin
							packed_n = {packed_q[23:0], b};
						end
						if (hdr_q == 3'd7) begin
							hdr_n   = '0;
							phase_n = lzss_dec_pkg::PH_BODY;
							fin_n   = (left_q == '0);
						end else begin
							hdr_n = hdr_q + 3'd1;
						end
					end
					default: begin
						if (!fin_q && consumed_q < packed_q) begin
							consumed_n = consumed_q + 32'd1;
							if (phase_q == lzss_dec_pkg::PH_MATCH2) begin
								if (32'(len_raw) >= left_q) begin
									n        = left_q[lzss_dec_pkg::LEN_W-1:0];
									cmd.done = 1'b1;
								end else begin
									n = len_raw;
								end
								left_n       = left_q - 32'(n);
								cmd.kind     = lzss_dec_pkg::CMD_MATCH;
								cmd.len      = n;
								cmd_push     = (n != '0);
								phase_n      = lzss_dec_pkg::PH_BODY;
								flag_n       = flag_q >> 1;
								flags_left_n = flags_left_q - 4'(flags_left_q != '0);
								check        = 1'b1;
							end else if (flags_left_q == '0) begin
								flag_n       = b;
								flags_left_n = lzss_dec_pkg::FLAG_BITS;
								check        = 1'b1;
							end else if (flag_q[0]) begin
								left_n       = left_q - 32'd1;
								cmd.kind     = lzss_dec_pkg::CMD_LIT;
								cmd.done     = (left_q == 32'd1);
								cmd_push     = 1'b1;
								flag_n       = flag_q >> 1;
								flags_left_n = flags_left_q - 4'(flags_left_q != '0);
								check        = 1'b1;
							end else begin
								low_n   = b;
								phase_n = lzss_dec_pkg::PH_MATCH2;
							end
						end
					end
				endcase
			end
		end
		if (check) begin
			fin_n = (left_n == '0) ||
				(flags_left_n != '0 && !flag_n[0] && left_n == 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= lzss_dec_pkg::PH_HEADER;
			hdr_q        <= '0;
			left_q       <= '0;
			packed_q     <= '0;
			consumed_q   <= '0;
			flag_q       <= '0;
			flags_left_q <= '0;
			low_q        <= '0;
			fin_q        <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			hdr_q        <= hdr_n;
			left_q       <= left_n;
			packed_q     <= packed_n;
			consumed_q   <= consumed_n;
			flag_q       <= flag_n;
			flags_left_q <= flags_left_n;
			low_q        <= low_n;
			fin_q        <= fin_n;
		end
	end

endmodule

>>> design/lzss_dec_cmd_queue.sv
// Short command queue between the parser and the copy engine.
module lzss_dec_cmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lzss_dec_pkg::cmd_t wdata,
	output logic               full,
	input  logic               pop,
	output lzss_dec_pkg::cmd_t rdata,
	output logic               empty
);

	lzss_dec_pkg::cmd_t              entry_q [lzss_dec_pkg::CMD_DEPTH];
	logic [lzss_dec_pkg::CMD_AW-1:0] wr_q;
	logic [lzss_dec_pkg::CMD_AW-1:0] rd_q;
	logic [lzss_dec_pkg::CMD_AW:0]   count_q;

	assign full  = (count_q == (lzss_dec_pkg::CMD_AW+1)'(lzss_dec_pkg::CMD_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + (lzss_dec_pkg::CMD_AW+1)'(push)
				- (lzss_dec_pkg::CMD_AW+1)'(pop);
		end
	end

endmodule

>>> design/lzss_dec_copy.sv
// Back end: executes commands against the history window and buffers output.
module lzss_dec_copy (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_empty,
	input  lzss_dec_pkg::cmd_t                cmd_head,
	output logic                              cmd_pop,
	output logic                              ram_we,
	output logic [lzss_dec_pkg::WIN_AW-1:0]   ram_waddr,
	output logic [7:0]                        ram_wdata,
	output logic [lzss_dec_pkg::WIN_AW-1:0]   ram_raddr,
	input  logic [7:0]                        ram_rdata,
	output logic                              res_valid,
	input  logic                              res_stall,
	output lzss_dec_pkg::out_req_t            res
);

	logic                              active_q;
	lzss_dec_pkg::cmd_kind_t           kind_q;
	logic [lzss_dec_pkg::WIN_AW-1:0]   src_q;
	logic [lzss_dec_pkg::LEN_W-1:0]    rem_q;
	logic [7:0]                        lit_q;
	logic                              done_q;
	logic [lzss_dec_pkg::WIN_AW-1:0]   wpos_q;
	logic [lzss_dec_pkg::FILL_W-1:0]   fill_q;

	logic                              v_s1;
	logic                              lit_sel_s1;
	logic                              zero_s1;
	logic                              byp_s1;
	logic [7:0]                        byp_data_s1;
	logic [7:0]                        lit_data_s1;
	logic [lzss_dec_pkg::WIN_AW-1:0]   waddr_s1;
	logic                              last_s1;
	logic                              done_s1;

	lzss_dec_pkg::out_req_t            obuf_q [2];
	logic                              owr_q;
	logic                              ord_q;
	logic [1:0]                        occ_q;

	logic                              opop;
	logic                              credit;
	logic                              is_frame;
	logic                              issue;
	logic                              cmd_end;
	logic [lzss_dec_pkg::WIN_AW-1:0]   src_dist;
	logic                              in_win;
	logic [7:0]                        wdata_b;

	assign opop     = (occ_q != '0) && !res_stall;
	assign credit   = ({1'b0, occ_q} + {2'b0, v_s1}) <= (3'd1 + {2'b0, opop});
	assign is_frame = active_q && (kind_q == lzss_dec_pkg::CMD_FRAME);
	assign issue    = active_q && (kind_q != lzss_dec_pkg::CMD_FRAME) && credit;
	assign cmd_end  = is_frame || (issue && rem_q == lzss_dec_pkg::LEN_W'(1));
	assign cmd_pop  = !cmd_empty && (!active_q || cmd_end);

	assign src_dist = src_q - lzss_dec_pkg::START_POS;
	assign in_win   = {1'b0, src_dist} < fill_q;

	assign wdata_b = lit_sel_s1 ? lit_data_s1 :
		zero_s1 ? 8'd0 :
		byp_s1 ? byp_data_s1 : ram_rdata;

	assign ram_we    = v_s1;
	assign ram_waddr = waddr_s1;
	assign ram_wdata = wdata_b;
	assign ram_raddr = src_q;

	assign res_valid = (occ_q != '0);
	assign res       = obuf_q[ord_q];

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			kind_q <= cmd_head.kind;
			lit_q  <= cmd_head.lit;
			done_q <= cmd_head.done;
		end
		if (issue) begin
			lit_sel_s1  <= (kind_q == lzss_dec_pkg::CMD_LIT);
			zero_s1     <= !in_win;
			byp_s1      <= v_s1 && (waddr_s1 == src_q);
			byp_data_s1 <= wdata_b;
			lit_data_s1 <= lit_q;
			waddr_s1    <= wpos_q;
			last_s1     <= (rem_q == lzss_dec_pkg::LEN_W'(1));
			done_s1     <= done_q && (rem_q == lzss_dec_pkg::LEN_W'(1));
		end
		if (v_s1) begin
			obuf_q[owr_q] <= '{out_byte: wdata_b, run_last: last_s1, frame_done: done_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			src_q    <= '0;
			rem_q    <= '0;
			wpos_q   <= lzss_dec_pkg::START_POS;
			fill_q   <= '0;
			v_s1     <= 1'b0;
			owr_q    <= 1'b0;
			ord_q    <= 1'b0;
			occ_q    <= '0;
		end else begin
			if (cmd_pop) begin
				active_q <= 1'b1;
				src_q    <= cmd_head.off;
				rem_q    <= cmd_head.len;
			end else begin
				if (cmd_end) begin
					active_q <= 1'b0;
				end
				if (issue) begin
					src_q <= src_q + 1'b1;
					rem_q <= rem_q - 1'b1;
				end
			end
			if (is_frame) begin
				wpos_q <= lzss_dec_pkg::START_POS;
				fill_q <= '0;
			end else if (issue) begin
				wpos_q <= wpos_q + 1'b1;
				if (fill_q != lzss_dec_pkg::FILL_FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			v_s1 <= issue;
			if (v_s1) begin
				owr_q <= ~owr_q;
			end
			if (opop) begin
				ord_q <= ~ord_q;
			end
			occ_q <= occ_q + 2'(v_s1) - 2'(opop);
		end
	end

endmodule

>>> design/lzss_byte_decompressor_unit.sv
// Top level of the LZSS byte decompressor: parser, command queue, copy engine and window.
// Compressed frame bytes (8-byte header of big-endian output and body lengths, then
// control bytes, literals and two-byte matches) are taken one per cycle while the
// command queue has room; the parser itself adds no stall of its own.
// The copy engine then writes one output byte per cycle while its output buffer has
// room into the 4096-byte history window, a single-read-port RAM: a literal writes one
// byte, a match of n bytes writes n bytes (up to 18), and the marker that a frame start
// places in the queue writes none. Sustained throughput is therefore set by the match
// lengths. Each frame start resets the window to zeros logically through a fill count,
// so no clearing pass is needed.
module lzss_byte_decompressor_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   comp_valid,
	output logic                   comp_stall,
	input  lzss_dec_pkg::in_req_t  comp_req,
	output logic                   dec_valid,
	input  logic                   dec_stall,
	output lzss_dec_pkg::out_req_t dec_req
);

	logic                            cmd_push;
	lzss_dec_pkg::cmd_t              cmd_in;
	logic                            cmd_full;
	logic                            cmd_pop;
	lzss_dec_pkg::cmd_t              cmd_head;
	logic                            cmd_empty;
	logic                            ram_we;
	logic [lzss_dec_pkg::WIN_AW-1:0] ram_waddr;
	logic [7:0]                      ram_wdata;
	logic [lzss_dec_pkg::WIN_AW-1:0] ram_raddr;
	logic [7:0]                      ram_rdata;

	lzss_dec_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (comp_valid),
		.req_stall (comp_stall),
		.req       (comp_req),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	lzss_dec_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	lzss_dec_copy u_copy (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (dec_valid),
		.res_stall (dec_stall),
		.res       (dec_req)
	);

	lzss_dec_ram #(
		.WIDTH (8),
		.DEPTH (lzss_dec_pkg::WINDOW_SIZE)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

>>> bench/lzss_byte_decompressor_unit_tb.sv
// Self-checking testbench for the LZSS byte decompressor: directed and random frames.
`timescale 1ns / 1ps

module lzss_byte_decompressor_unit_tb;

	localparam int LIMIT        = 500000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;

	typedef logic [7:0] byte_q_t[$];

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   comp_valid;
	logic                   comp_stall;
	lzss_dec_pkg::in_req_t  comp_req;
	logic                   dec_valid;
	logic                   dec_stall;
	lzss_dec_pkg::out_req_t dec_req;

	bit                     idle_en;
	bit                     hold_req;
	int                     errors;
	int                     cycles;
	int                     bytes_sent;
	int                     live_items;
	int                     frames_sent;
	int                     bytes_checked;
	lzss_dec_pkg::out_req_t owed_bytes[$];
	lzss_dec_pkg::out_req_t step_run[$];
	lzss_dec_pkg::out_req_t want_req;

	logic [7:0]           hist [lzss_dec_pkg::WINDOW_SIZE];
	logic [11:0]          wr_pos;
	logic [7:0]           ctrl_bits;
	logic [3:0]           ctrl_left;
	lzss_dec_pkg::phase_t parse_ph;
	logic [2:0]           hdr_cnt;
	logic [7:0]           match_lo;
	logic [31:0]          dec_len;
	logic [31:0]          body_len;
	logic [31:0]          made_cnt;
	logic [31:0]          used_cnt;
	bit                   frame_over;

	lzss_byte_decompressor_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.comp_valid (comp_valid),
		.comp_stall (comp_stall),
		.comp_req   (comp_req),
		.dec_valid  (dec_valid),
		.dec_stall  (dec_stall),
		.dec_req    (dec_req)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void restart_frame();
		foreach (hist[i]) hist[i] = '0;
		wr_pos     = lzss_dec_pkg::START_POS;
		ctrl_bits  = '0;
		ctrl_left  = '0;
		parse_ph   = lzss_dec_pkg::PH_HEADER;
		hdr_cnt    = '0;
		match_lo   = '0;
		dec_len    = '0;
		body_len   = '0;
		made_cnt   = '0;
		used_cnt   = '0;
		frame_over = 1'b0;
	endfunction

	function automatic void put_byte(logic [7:0] b);
		lzss_dec_pkg::out_req_t r;
		hist[wr_pos] = b;
		wr_pos++;
		made_cnt++;
		r.out_byte   = b;
		r.run_last   = 1'b0;
		r.frame_done = made_cnt >= dec_len;
		step_run.insert(step_run.size(), r);
		if (made_cnt >= dec_len)
			frame_over = 1'b1;
	endfunction

	function automatic void shift_flags();
		ctrl_bits = ctrl_bits >> 1;
		if (ctrl_left != 0)
			ctrl_left--;
	endfunction

	// returns 0 when the byte is dropped by the block
	function automatic bit decompress_byte(logic [7:0] b, logic fs);
		logic [11:0] src;
		logic [31:0] run_len;
		logic [31:0] left;
		if (fs)
			restart_frame();
		if (parse_ph == lzss_dec_pkg::PH_HEADER) begin
			if (hdr_cnt < 3'd4)
				dec_len = {dec_len[23:0], b};
			else
				body_len = {body_len[23:0], b};
			if (hdr_cnt == 3'd7) begin
				hdr_cnt  = '0;
				parse_ph = lzss_dec_pkg::PH_BODY;
				if (dec_len == 0)
					frame_over = 1'b1;
			end else begin
				hdr_cnt++;
			end
			return 1'b1;
		end
		if (frame_over || used_cnt >= body_len)
			return 1'b0;
		used_cnt++;
		if (parse_ph == lzss_dec_pkg::PH_MATCH2) begin
			src     = {b[7:4], match_lo};
			run_len = 32'(b[3:0]) + 32'd3;
			left    = dec_len - made_cnt;
			if (run_len > left)
				run_len = left;
			repeat (run_len) begin
				put_byte(hist[src]);
				src++;
			end
			parse_ph = lzss_dec_pkg::PH_BODY;
			shift_flags();
		end else if (ctrl_left == 0) begin
			ctrl_bits = b;
			ctrl_left = lzss_dec_pkg::FLAG_BITS;
		end else if (ctrl_bits[0]) begin
			put_byte(b);
			shift_flags();
		end else begin
			match_lo = b;
			parse_ph = lzss_dec_pkg::PH_MATCH2;
			return 1'b1;
		end
		if (!frame_over && ctrl_left != 0 && !ctrl_bits[0] && dec_len - made_cnt == 1)
			frame_over = 1'b1;
		if (step_run.size() != 0)
			step_run[step_run.size() - 1].run_last = 1'b1;
		foreach (step_run[i])
			owed_bytes.insert(owed_bytes.size(), step_run[i]);
		step_run.delete();
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fs);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			comp_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		// hold the request until taken
		comp_valid <= 1'b1;
		comp_req   <= '{in_byte: b, frame_start: fs};
		do @(posedge clk); while (comp_stall);
		if (decompress_byte(b, fs))
			live_items++;
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic fs, input logic [31:0] total, input logic [31:0] packed_len,
			input byte_q_t body);
		logic [63:0] hdr;
		hdr = {total, packed_len};
		for (int i = 0; i < 8; i++)
			send_byte(hdr[63 - 8 * i -: 8], fs && i == 0);
		foreach (body[i])
			send_byte(body[i], 1'b0);
		frames_sent++;
	endtask

	task automatic random_frame(input bit clean);
		byte_q_t     body;
		int unsigned n_items;
		int unsigned made;
		int unsigned k;
		logic [31:0] total;
		logic [31:0] packed_len;
		logic [7:0]  ctrl;
		logic [11:0] off;
		logic [3:0]  nib;
		n_items = $urandom_range(3, 14);
		made    = 0;
		ctrl    = '0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 8 == 0) begin
				ctrl = 8'($urandom);
				body.insert(body.size(), ctrl);
			end
			if (ctrl[i % 8]) begin
				body.insert(body.size(), 8'($urandom));
				made++;
			end else begin
				nib = ($urandom_range(0, 7) == 0) ? 4'hF : 4'($urandom_range(0, 5));
				if (made != 0 && $urandom_range(0, 3) != 0)
					off = lzss_dec_pkg::START_POS + 12'(made)
						- 12'($urandom_range(1, (made < 24) ? made : 24));
				else
					off = 12'($urandom);
				body.insert(body.size(), off[7:0]);
				body.insert(body.size(), {off[11:8], nib});
				made += 32'(nib) + 3;
			end
		end
		case ($urandom_range(0, 9))
			6, 7:    total = $urandom_range(1, made);
			8:       total = $urandom_range(0, 1) ? 32'hFFFF_FFFF : made + $urandom_range(1, 10);
			9:       total = $urandom_range(0, 2);
			default: total = made;
		endcase
		case ($urandom_range(0, 5))
			0:       packed_len = $urandom_range(0, body.size());
			1:       packed_len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : body.size() + $urandom_range(1, 9);
			default: packed_len = body.size();
		endcase
		if (!clean) begin
			case ($urandom_range(0, 2))
				0: begin
					// cut the frame short so the next frame start abandons it
					k = $urandom_range(0, body.size() - 1);
					while (body.size() > k)
						void'(body.pop_back());
				end
				1: repeat ($urandom_range(1, 4)) body.insert(body.size(), 8'($urandom));
				default: body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
			endcase
		end
		send_frame(clean || $urandom_range(0, 3) != 0, total, packed_len, body);
	endtask

	task automatic test_truncated_overlap_match();
		// no frame start after reset; overlapping run of 0xFF cut at 15 bytes
		send_frame(1'b0, 32'd15, 32'd4, '{8'h01, 8'hFF, 8'hEE, 8'hFF, 8'h00});
	endtask

	task automatic test_abandoned_header();
		send_byte(8'h12, 1'b1);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
	endtask

	task automatic test_zero_length();
		send_frame(1'b1, 32'd0, 32'hFFFF_FFFF, '{8'hAA});
	endtask

	task automatic test_one_byte_left();
		send_frame(1'b1, 32'd5, 32'd4, '{8'h01, 8'h00, 8'h00, 8'h00, 8'h5A});
	endtask

	task automatic test_past_packed_length();
		send_frame(1'b1, 32'd8, 32'd2, '{8'hFE, 8'h34, 8'h12, 8'h77});
	endtask

	task automatic test_random_frames();
		int start;
		start = live_items;
		while (live_items - start < 20)
			random_frame($urandom_range(0, 4) != 0);
	endtask

	task automatic test_receiver_hold();
		byte_q_t body;
		hold_req = 1'b1;
		for (int g = 0; g < 2; g++) begin
			body.insert(body.size(), 8'hFF);
			for (int i = 0; i < 8; i++)
				body.insert(body.size(), 8'($urandom));
		end
		send_frame(1'b1, 32'd16, 32'd18, body);
	endtask

	task automatic test_no_idle();
		int start;
		idle_en = 1'b0;
		start   = live_items;
		while (live_items - start < 10)
			random_frame(1'b1);
	endtask

	always @(posedge clk) begin
		if (arst_n && dec_valid && !dec_stall) begin
			if (owed_bytes.size() == 0) begin
				$error("out_byte: expected none, got %02h", dec_req.out_byte);
				errors++;
			end else begin
				want_req = owed_bytes.pop_front();
				bytes_checked++;
				if (dec_req.out_byte !== want_req.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want_req.out_byte, dec_req.out_byte);
					errors++;
				end
				if (dec_req.run_last !== want_req.run_last) begin
					$error("run_last: expected %0b, got %0b", want_req.run_last, dec_req.run_last);
					errors++;
				end
				if (dec_req.frame_done !== want_req.frame_done) begin
					$error("frame_done: expected %0b, got %0b", want_req.frame_done,
						dec_req.frame_done);
					errors++;
				end
			end
		end
	end

	initial begin
		dec_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				dec_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				dec_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				dec_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				dec_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		comp_valid = 1'b0;
		comp_req   = '0;
		idle_en    = 1'b1;
		hold_req   = 1'b0;
		restart_frame();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_truncated_overlap_match();
		test_abandoned_header();
		test_zero_length();
		test_one_byte_left();
		test_past_packed_length();
		test_random_frames();
		test_receiver_hold();
		test_no_idle();
		comp_valid <= 1'b0;
		while (owed_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d compressed bytes (%0d decoded) in %0d frames; checked %0d output bytes.",
			bytes_sent, live_items, frames_sent, bytes_checked);
		$display("Included abandoned, zero-length and truncated frames and a long output hold-off.");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/lzss_dec_pkg.sv
design/lzss_dec_ram.sv
design/lzss_dec_parser.sv
design/lzss_dec_cmd_queue.sv
design/lzss_dec_copy.sv
design/lzss_byte_decompressor_unit.sv
bench/lzss_byte_decompressor_unit_tb.sv
